>>> design/rc5_pkg.sv
`default_nettype none

package rc5_pkg;

    localparam int ROUND_COUNT = 12;
    localparam int TABLE_DEPTH = 2 * (ROUND_COUNT + 1);
    localparam int BANK_DEPTH  = ROUND_COUNT + 1;
    localparam int BANK_AW     = $clog2(BANK_DEPTH);
    localparam int WORD_W      = 32;
    localparam int INDEX_W     = 5;
    localparam int ROT_W       = 5;
    localparam int IN_DATA_W   = 104;
    localparam int OUT_DATA_W  = 64;

    typedef logic [WORD_W-1:0]  t_word;
    typedef logic [BANK_AW-1:0] t_round;
    typedef logic [1:0]         t_cmd;

    localparam t_cmd CMD_LOAD = 2'd0;
    localparam t_cmd CMD_ENC  = 2'd1;
    localparam t_cmd CMD_DEC  = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    // {x,x} shifted keeps a zero amount from touching the word
    function automatic t_word rotl(input t_word x, input logic [ROT_W-1:0] s);
        logic [2*WORD_W-1:0] t;
        t = {x, x} << s;
        return t[2*WORD_W-1:WORD_W];
    endfunction

    function automatic t_word rotr(input t_word x, input logic [ROT_W-1:0] s);
        logic [2*WORD_W-1:0] t;
        t = {x, x} >> s;
        return t[WORD_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> design/rc5_ram.sv
`default_nettype none

module rc5_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 13,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> design/rc5_block_cipher_core.sv
// RC5-32/12 core. Load request: accepted only while idle, and ready stays high.
// Encrypt/decrypt: subkeys prefetched on the accepting edge, then whitening and 12
// rounds (decrypt: rounds, then whitening), one per cycle, but the last one is held while
// a finished result waits downstream; no new block is taken until the last step is done.
// Subkeys sit in two 13-word banks (even/odd) so a round reads both at once.
// Reset (i_rst_n low, synchronous) clears the state and output valid; banks keep data.
`default_nettype none

module rc5_block_cipher_core
    import rc5_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // key_index[4:0], key_word[36:5], word_a[68:37], word_b[100:69], zero pad
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // cmd[1:0]
    input  wire logic [1:0]            s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // out_a[31:0], out_b[63:32]
    output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

    t_state r_state, n_state;
    t_round r_cnt, n_cnt;
    logic   r_dec, n_dec;
    t_word  r_a, n_a, r_b, n_b;
    logic   r_out_valid, n_out_valid;
    t_word  r_out_a, n_out_a, r_out_b, n_out_b;

    logic               in_acc;
    t_cmd               in_cmd;
    logic [INDEX_W-1:0] in_idx;
    t_word              in_key, in_a, in_b;
    logic               load_ok;
    t_round             rd_addr;
    t_word              s_even, s_odd;
    logic               last, step_en;
    t_word              ea, eb, da, db;

    assign in_cmd = s_axis_tuser;
    assign in_idx = s_axis_tdata[4:0];
    assign in_key = s_axis_tdata[36:5];
    assign in_a   = s_axis_tdata[68:37];
    assign in_b   = s_axis_tdata[100:69];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign load_ok       = in_acc && (in_cmd == CMD_LOAD) && (in_idx < INDEX_W'(TABLE_DEPTH));

    rc5_ram #(.WIDTH(WORD_W), .DEPTH(BANK_DEPTH)) u_bank_even (
        .i_clk   (i_clk),
        .i_we    (load_ok && !in_idx[0]),
        .i_waddr (in_idx[INDEX_W-1:1]),
        .i_wdata (in_key),
        .i_raddr (rd_addr),
        .o_rdata (s_even)
    );

    rc5_ram #(.WIDTH(WORD_W), .DEPTH(BANK_DEPTH)) u_bank_odd (
        .i_clk   (i_clk),
        .i_we    (load_ok && in_idx[0]),
        .i_waddr (in_idx[INDEX_W-1:1]),
        .i_wdata (in_key),
        .i_raddr (rd_addr),
        .o_rdata (s_odd)
    );

    // round unit: encrypt counts up from whitening, decrypt counts down to it
    always_comb begin
        ea = rotl(r_a ^ r_b, r_b[ROT_W-1:0]) + s_even;
        eb = rotl(r_b ^ ea, ea[ROT_W-1:0]) + s_odd;
        db = rotr(r_b - s_odd, r_a[ROT_W-1:0]) ^ r_a;
        da = rotr(r_a - s_even, db[ROT_W-1:0]) ^ db;
    end

    assign last    = r_dec ? (r_cnt == '0) : (r_cnt == BANK_AW'(ROUND_COUNT));
    // hold the final step while the previous result is still waiting
    assign step_en = !(last && r_out_valid && !m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_cnt   <= n_cnt;
        r_dec   <= n_dec;
        r_a     <= n_a;
        r_b     <= n_b;
        r_out_a <= n_out_a;
        r_out_b <= n_out_b;
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_dec       = r_dec;
        n_a         = r_a;
        n_b         = r_b;
        n_out_a     = r_out_a;
        n_out_b     = r_out_b;
        n_out_valid = r_out_valid && !m_axis_tready;
        rd_addr     = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                rd_addr = (in_cmd == CMD_DEC) ? BANK_AW'(ROUND_COUNT) : '0;
                if (in_acc && (in_cmd == CMD_ENC || in_cmd == CMD_DEC)) begin
                    n_state = ST_RUN;
                    n_dec   = (in_cmd == CMD_DEC);
                    n_cnt   = rd_addr;
                    n_a     = in_a;
                    n_b     = in_b;
                end
            end
            ST_RUN: begin
                if (step_en) begin
                    if (!last) begin
                        rd_addr = r_dec ? r_cnt - 1'b1 : r_cnt + 1'b1;
                        n_cnt   = rd_addr;
                    end
                    if (r_dec) begin
                        if (r_cnt == '0) begin
                            n_a = r_a - s_even;
                            n_b = r_b - s_odd;
                        end else begin
                            n_a = da;
                            n_b = db;
                        end
                    end else begin
                        if (r_cnt == '0) begin
                            n_a = r_a + s_even;
                            n_b = r_b + s_odd;
                        end else begin
                            n_a = ea;
                            n_b = eb;
                        end
                    end
                    if (last) begin
                        n_state     = ST_IDLE;
                        n_out_valid = 1'b1;
                        n_out_a     = n_a;
                        n_out_b     = n_b;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_b, r_out_a};

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (in_cmd == CMD_ENC || in_cmd == CMD_DEC) |=>
            r_state == ST_RUN && r_dec == ($past(in_cmd) == CMD_DEC)
            && r_cnt == (r_dec ? BANK_AW'(ROUND_COUNT) : '0))
        else $error("block start mis-sequenced");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_RUN |-> r_cnt <= BANK_AW'(ROUND_COUNT))
        else $error("round counter out of range");

    a_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_RUN && last && step_en |=> r_out_valid && r_state == ST_IDLE)
        else $error("finished block not presented");

    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_RUN && last && r_out_valid && !m_axis_tready |=>
            r_state == ST_RUN && $stable(r_a) && $stable(r_b))
        else $error("final step not held while output blocked");

endmodule

`default_nettype wire

>>> bench/rc5_checker.sv
`timescale 1ns / 100ps

module rc5_checker
    import rc5_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_req_valid,
    input  wire logic                  i_req_ready,
    // key_index[4:0], key_word[36:5], word_a[68:37], word_b[100:69], zero pad
    input  wire logic [IN_DATA_W-1:0]  i_req_data,
    // cmd[1:0]
    input  wire logic [1:0]            i_req_cmd,
    input  wire logic                  i_res_valid,
    input  wire logic                  i_res_ready,
    // out_a[31:0], out_b[63:32]
    input  wire logic [OUT_DATA_W-1:0] i_res_data,
    output int                         o_pending,
    output int                         o_fail_count
);

    // b in the upper half so the packed value lines up with the result bus
    typedef struct packed {
        t_word b;
        t_word a;
    } t_block;

    t_word  subkeys [TABLE_DEPTH];
    t_block block_q [$];

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
        for (int i = 0; i < TABLE_DEPTH; i++) subkeys[i] = '0;
    end

    function automatic t_word rot_l(input t_word x, input int s);
        if (s == 0) return x;
        return (x << s) | (x >> (32 - s));
    endfunction

    function automatic t_word rot_r(input t_word x, input int s);
        if (s == 0) return x;
        return (x >> s) | (x << (32 - s));
    endfunction

    function automatic t_block encipher(input t_word a_in, input t_word b_in);
        t_word  a;
        t_word  b;
        t_block r;
        a = a_in + subkeys[0];
        b = b_in + subkeys[1];
        for (int i = 1; i <= ROUND_COUNT; i++) begin
            a = rot_l(a ^ b, int'(b[4:0])) + subkeys[2*i];
            b = rot_l(b ^ a, int'(a[4:0])) + subkeys[2*i+1];
        end
        r.a = a;
        r.b = b;
        return r;
    endfunction

    function automatic t_block decipher(input t_word a_in, input t_word b_in);
        t_word  a;
        t_word  b;
        t_block r;
        a = a_in;
        b = b_in;
        for (int i = ROUND_COUNT; i >= 1; i--) begin
            b = rot_r(b - subkeys[2*i+1], int'(a[4:0])) ^ a;
            a = rot_r(a - subkeys[2*i], int'(b[4:0])) ^ b;
        end
        r.a = a - subkeys[0];
        r.b = b - subkeys[1];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input t_word got, input t_word want);
        $display("ERROR at %0t: %s got %h want %h", $time, what, got, want);
        o_fail_count = o_fail_count + 1;
    endtask

    always @(posedge i_clk) begin
        logic [INDEX_W-1:0] slot;
        t_word              key;
        t_word              wa;
        t_word              wb;
        t_block             want;
        t_block             got;
        slot = i_req_data[4:0];
        key  = i_req_data[36:5];
        wa   = i_req_data[68:37];
        wb   = i_req_data[100:69];
        got  = i_res_data;
        if (i_rst_n) begin
            if (i_req_valid && i_req_ready) begin
                case (i_req_cmd)
                    CMD_LOAD: begin
                        if (slot < TABLE_DEPTH) subkeys[slot] = key;
                    end
                    CMD_ENC: block_q.push_back(encipher(wa, wb));
                    CMD_DEC: block_q.push_back(decipher(wa, wb));
                    default: ;
                endcase
            end
            if (i_res_valid && i_res_ready) begin
                if (block_q.size() == 0) begin
                    report_mismatch("unrequested result, out_a", got.a, '0);
                end else begin
                    want = block_q.pop_front();
                    if (got.a !== want.a) report_mismatch("out_a", got.a, want.a);
                    if (got.b !== want.b) report_mismatch("out_b", got.b, want.b);
                end
            end
        end
        o_pending <= block_q.size();
    end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import rc5_pkg::*;

    localparam t_cmd CMD_NONE       = 2'd3;
    localparam int   RANDOM_ITEMS   = 1550;
    localparam int   HOLD_CYCLES    = 300;
    localparam int   WATCHDOG_LIMIT = 3000;
    localparam int   DRAIN_CYCLES   = 40;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [1:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    int  pending;
    int  fail_count;
    bit  tx_gaps       = 1'b1;
    bit  rx_steady     = 1'b0;
    int  hold_requests = 0;
    int  holds_served  = 0;
    int  idle_cycles   = 0;
    int  n_load        = 0;
    int  n_load_skip   = 0;
    int  n_enc         = 0;
    int  n_dec         = 0;
    int  n_unused      = 0;

    rc5_block_cipher_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    rc5_checker cipher_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (s_axis_tvalid),
        .i_req_ready  (s_axis_tready),
        .i_req_data   (s_axis_tdata),
        .i_req_cmd    (s_axis_tuser),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // result side: random back-pressure, or a long counted hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holds_served < hold_requests) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                holds_served++;
            end else begin
                m_axis_tready <= rx_steady || ($urandom_range(0, 99) >= 27);
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no traffic for %0d cycles, %0d blocks outstanding",
                         idle_cycles, pending);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    function automatic t_word pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_request(input t_cmd cmd, input logic [INDEX_W-1:0] idx,
                                input t_word key, input t_word a, input t_word b);
        while (tx_gaps && $urandom_range(0, 99) < 27) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, b, a, key, idx};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        @(negedge i_clk);
        case (cmd)
            CMD_LOAD: begin
                if (idx < TABLE_DEPTH) n_load++;
                else n_load_skip++;
            end
            CMD_ENC: n_enc++;
            CMD_DEC: n_dec++;
            default: n_unused++;
        endcase
    endtask

    task automatic load_table(input bit all_zero);
        for (int i = 0; i < TABLE_DEPTH; i++)
            push_request(CMD_LOAD, INDEX_W'(i), all_zero ? 32'h0 : pick_word(), $urandom,
                         $urandom);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        @(negedge i_clk);
    endtask

    initial begin
        int  n;
        int  roll;
        bit  steady_done;
        bit  hold_done;
        bit  pause_done;
        n           = 0;
        steady_done = 1'b0;
        hold_done   = 1'b0;
        pause_done  = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_LOAD;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // all-zero key table: with an all-zero block every rotation amount is zero
        load_table(1'b1);
        push_request(CMD_ENC, 5'd0, 32'h0, 32'h0000_0000, 32'h0000_0000);
        push_request(CMD_ENC, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_request(CMD_DEC, 5'd0, 32'h0, 32'h0000_0000, 32'h0000_0000);
        push_request(CMD_DEC, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // slots past the table end are dropped
        push_request(CMD_LOAD, 5'd26, 32'hFFFF_FFFF, 32'h0, 32'h0);
        push_request(CMD_LOAD, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_request(CMD_NONE, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_request(CMD_ENC, 5'd0, 32'h0, 32'h0000_0000, 32'hFFFF_FFFF);
        // extreme subkeys at both ends of the table
        push_request(CMD_LOAD, 5'd0, 32'hFFFF_FFFF, 32'h0, 32'h0);
        push_request(CMD_LOAD, 5'd25, 32'hFFFF_FFFF, 32'h0, 32'h0);
        push_request(CMD_ENC, 5'd0, 32'h0, 32'hFFFF_FFFF, 32'h0000_0000);
        push_request(CMD_DEC, 5'd0, 32'h0, 32'h0000_0000, 32'hFFFF_FFFF);
        push_request(CMD_DEC, 5'd0, 32'h0, 32'h8000_0001, 32'h0000_0020);

        load_table(1'b0);
        n = TABLE_DEPTH;
        while (n < RANDOM_ITEMS) begin
            if (!steady_done && n >= 400) begin
                tx_gaps   = 1'b0;
                rx_steady = 1'b1;
            end
            if (!steady_done && n >= 650) begin
                tx_gaps     = 1'b1;
                rx_steady   = 1'b0;
                steady_done = 1'b1;
            end
            if (!hold_done && n >= 800) begin
                hold_requests++;
                hold_done = 1'b1;
            end
            if (!pause_done && n >= 1000) begin
                wait_drained();
                pause_done = 1'b1;
            end
            roll = $urandom_range(0, 99);
            if (roll < 2) begin
                load_table(1'b0);
                n += TABLE_DEPTH;
            end else if (roll < 14) begin
                push_request(CMD_LOAD, INDEX_W'($urandom_range(0, 31)), pick_word(),
                             $urandom, $urandom);
                if (s_axis_tdata[4:0] < TABLE_DEPTH) n++;
            end else if (roll < 18) begin
                push_request(CMD_NONE, INDEX_W'($urandom), $urandom, $urandom, $urandom);
            end else begin
                push_request(roll < 59 ? CMD_ENC : CMD_DEC, INDEX_W'($urandom), $urandom,
                             pick_word(), pick_word());
                n++;
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d subkey loads, %0d out-of-range loads, %0d unused commands",
                 n_load, n_load_skip, n_unused);
        $display("%0d encrypts and %0d decrypts, with a %0d-cycle output hold-off",
                 n_enc, n_dec, HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
